### rtl/quote_aware_comment_stripper_assert.svh
// assertion macros for the comment stripper
`ifndef QUOTE_AWARE_COMMENT_STRIPPER_ASSERT_SVH
`define QUOTE_AWARE_COMMENT_STRIPPER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define QACS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qacs assertion failed");

// antecedent implies consequent in the following cycle
`define QACS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qacs assertion failed");

`endif

### rtl/qacs_pkg.sv
// shared types and constants of the comment stripper
`default_nettype none
package qacs_pkg;

    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_SLASH      = 3'd1;
    localparam logic [2:0] MODE_STRING     = 3'd2;
    localparam logic [2:0] MODE_ESCAPE     = 3'd3;
    localparam logic [2:0] MODE_BLOCK      = 3'd4;
    localparam logic [2:0] MODE_BLOCK_STAR = 3'd5;
    localparam logic [2:0] MODE_LINE       = 3'd6;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    typedef logic [FIFO_AW-1:0] fifo_ptr_t;
    typedef logic [FIFO_AW:0]   fifo_cnt_t;

    typedef struct packed {
        logic [2:0] mode_next;
        logic [1:0] push_cnt;
    } step_ctl_t;

    typedef struct packed {
        fifo_cnt_t count;
        logic      room2;
    } fifo_stat_t;

endpackage
`default_nettype wire

### rtl/qacs_step.sv
// one scan step: mode update and up to two kept characters
`default_nettype none
module qacs_step
    import qacs_pkg::*;
#(
    parameter int CHAR_BITS = 16
)(
    input  wire logic [2:0]           mode,
    input  wire logic [CHAR_BITS-1:0] char_in,
    input  wire logic                 last_in,
    output step_ctl_t                 ctl,
    output logic [CHAR_BITS-1:0]      char0,
    output logic [CHAR_BITS-1:0]      char1
);

    logic hi_zero;
    logic is_bs;
    logic is_quote;
    logic is_slash;
    logic is_star;
    logic is_nl;
    logic [CHAR_BITS-1:0] slash_char;

    assign hi_zero    = (char_in >> 8) == '0;
    assign is_bs      = hi_zero && (char_in[7:0] == CH_BACKSLASH);
    assign is_quote   = hi_zero && (char_in[7:0] == CH_QUOTE);
    assign is_slash   = hi_zero && (char_in[7:0] == CH_SLASH);
    assign is_star    = hi_zero && (char_in[7:0] == CH_STAR);
    assign is_nl      = hi_zero && (char_in[7:0] == CH_NEWLINE);
    assign slash_char = CHAR_BITS'(CH_SLASH);

    always_comb
    begin
        logic [2:0] m;
        logic [1:0] n;
        m     = mode;
        n     = 2'd0;
        char0 = char_in;
        char1 = char_in;
        unique case (mode)
            MODE_SLASH:
            begin
                if (is_star)
                begin
                    m = MODE_BLOCK;
                end
                else if (is_slash)
                begin
                    m = MODE_LINE;
                end
                else
                begin
                    char0 = slash_char;
                    n     = 2'd2;
                    m     = is_quote ? MODE_STRING : MODE_NORMAL;
                end
            end
            MODE_STRING:
            begin
                n = 2'd1;
                if (is_bs && !last_in)
                begin
                    m = MODE_ESCAPE;
                end
                else if (is_quote)
                begin
                    m = MODE_NORMAL;
                end
            end
            MODE_ESCAPE:
            begin
                n = 2'd1;
                m = MODE_STRING;
            end
            MODE_BLOCK:
            begin
                if (is_star)
                begin
                    m = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR:
            begin
                if (is_slash)
                begin
                    m = MODE_NORMAL;
                end
                else if (!is_star)
                begin
                    m = MODE_BLOCK;
                end
            end
            MODE_LINE:
            begin
                if (is_nl)
                begin
                    n = 2'd1;
                    m = MODE_NORMAL;
                end
            end
            default:
            begin
                if (is_quote)
                begin
                    n = 2'd1;
                    m = MODE_STRING;
                end
                else if (is_slash && !last_in)
                begin
                    m = MODE_SLASH;
                end
                else
                begin
                    n = 2'd1;
                    m = MODE_NORMAL;
                end
            end
        endcase
        if (last_in)
        begin
            m = MODE_NORMAL;
        end
        ctl.mode_next = m;
        ctl.push_cnt  = n;
    end

endmodule
`default_nettype wire

### rtl/qacs_out_fifo.sv
// result queue taking up to two entries per cycle and giving one
`default_nettype none
module qacs_out_fifo
    import qacs_pkg::*;
#(
    parameter int CHAR_BITS = 16
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [1:0]           push_cnt,
    input  wire logic [CHAR_BITS-1:0] push_char0,
    input  wire logic [CHAR_BITS-1:0] push_char1,
    input  wire logic                 pop,
    output logic                      out_valid,
    output logic [CHAR_BITS-1:0]      out_char,
    output logic                      out_last,
    output fifo_stat_t                stat
);

    logic [CHAR_BITS-1:0] data_reg [FIFO_DEPTH];
    logic                 last_reg [FIFO_DEPTH];
    fifo_ptr_t            head_reg;
    fifo_ptr_t            head_next;
    fifo_ptr_t            tail_reg;
    fifo_ptr_t            tail_next;
    fifo_cnt_t            count_reg;
    fifo_cnt_t            count_next;
    fifo_ptr_t            tail_plus1;
    logic                 do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign tail_plus1 = tail_reg + fifo_ptr_t'(1);
    assign head_next  = do_pop ? head_reg + fifo_ptr_t'(1) : head_reg;
    assign tail_next  = tail_reg + fifo_ptr_t'(push_cnt);
    assign count_next = count_reg + fifo_cnt_t'(push_cnt) - fifo_cnt_t'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt == 2'd1)
        begin
            data_reg[tail_reg] <= push_char0;
            last_reg[tail_reg] <= 1'b1;
        end
        else if (push_cnt == 2'd2)
        begin
            data_reg[tail_reg]   <= push_char0;
            last_reg[tail_reg]   <= 1'b0;
            data_reg[tail_plus1] <= push_char1;
            last_reg[tail_plus1] <= 1'b1;
        end
    end

    assign out_valid  = count_reg != '0;
    assign out_char   = data_reg[head_reg];
    assign out_last   = last_reg[head_reg];
    assign stat.count = count_reg;
    assign stat.room2 = count_reg <= fifo_cnt_t'(FIFO_DEPTH - 2);

endmodule
`default_nettype wire

### rtl/quote_aware_comment_stripper.sv
// throughput: one input transaction per cycle while the result queue has room
// for two results, else the input stalls; results leave at one per cycle while
// m_axis_tready is high, so an input with two results takes two output transfers
// the mode step sits between the input register and the result queue
// reset: asynchronous active low, clears the input stage, queue and scan mode
`default_nettype none
module quote_aware_comment_stripper
    import qacs_pkg::*;
#(
    parameter int CHAR_BITS = 16
)(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [((CHAR_BITS+7)/8)*8-1:0]      s_axis_tdata,  // char_code
    input  wire logic                                s_axis_tlast,  // text_end
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [((CHAR_BITS+7)/8)*8-1:0]           m_axis_tdata,  // out_char
    output logic                                     m_axis_tlast   // run_last
);

    localparam int DATA_W = ((CHAR_BITS + 7) / 8) * 8;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [CHAR_BITS-1:0] in_char_reg;
    logic                 in_last_reg;
    logic [2:0]           mode_reg;
    logic [2:0]           mode_next;
    logic                 fire;
    logic                 in_take;
    step_ctl_t            ctl;
    fifo_stat_t           stat;
    logic [CHAR_BITS-1:0] char0;
    logic [CHAR_BITS-1:0] char1;
    logic [CHAR_BITS-1:0] q_char;

    assign fire          = in_valid_reg && stat.room2;
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign mode_next     = fire ? ctl.mode_next : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_NORMAL;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= s_axis_tdata[CHAR_BITS-1:0];
            in_last_reg <= s_axis_tlast;
        end
    end

    qacs_step #(
        .CHAR_BITS(CHAR_BITS)
    ) u_step (
        .mode    (mode_reg),
        .char_in (in_char_reg),
        .last_in (in_last_reg),
        .ctl     (ctl),
        .char0   (char0),
        .char1   (char1)
    );

    qacs_out_fifo #(
        .CHAR_BITS(CHAR_BITS)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (fire ? ctl.push_cnt : 2'd0),
        .push_char0 (char0),
        .push_char1 (char1),
        .pop        (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_char   (q_char),
        .out_last   (m_axis_tlast),
        .stat       (stat)
    );

    assign m_axis_tdata = DATA_W'(q_char);

`include "quote_aware_comment_stripper_assert.svh"

    `QACS_ASSERT_NOW(a_queue_bound, 1'b1, stat.count <= (FIFO_AW+1)'(FIFO_DEPTH))
    `QACS_ASSERT_NEXT(a_end_resets_mode, fire && in_last_reg, mode_reg == MODE_NORMAL)
    `QACS_ASSERT_NOW(a_held_slash_no_push, fire && (ctl.mode_next == MODE_SLASH), ctl.push_cnt == 2'd0)
    `QACS_ASSERT_NEXT(a_stall_keeps_item, in_valid_reg && !stat.room2, in_valid_reg)

endmodule
`default_nettype wire
